[src/one_euro_filter_bank_defines.svh]
// Assertion macros for the filter bank.
`ifndef ONE_EURO_FILTER_BANK_DEFINES_SVH
`define ONE_EURO_FILTER_BANK_DEFINES_SVH

// same-cycle implication
`define OEF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OEF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/oef_pkg.sv]
`timescale 1ns / 1ps
package oef_pkg;

  typedef struct packed {
    logic               rst;
    logic [5:0]         channel;
    logic signed [17:0] sample;
    logic [19:0]        us;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic        start;
    logic [31:0] cut;
    logic [19:0] us;
  } alpha_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] alpha;
  } alpha_rsp_t;

  typedef struct packed {
    logic [15:0] min_cutoff;
    logic [15:0] speed_gain;
    logic [15:0] deriv_cutoff;
  } cfg_t;

  typedef enum logic [2:0] {
    A_IDLE, A_LO, A_HI, A_DEN, A_DIV, A_FIN, A_DONE
  } alpha_st_t;

  typedef enum logic [3:0] {
    B_IDLE, B_READ, B_DIV, B_DSAT, B_ALPHA_D, B_SMD_MUL, B_SMD_ADD,
    B_CUT_MUL, B_CUT, B_ALPHA_X, B_SMX_MUL, B_SMX_ADD, B_OUT
  } back_st_t;

  localparam logic [1:0]  REG_MIN_CUTOFF   = 2'd0;
  localparam logic [1:0]  REG_SPEED_GAIN   = 2'd1;
  localparam logic [1:0]  REG_DERIV_CUTOFF = 2'd2;

  localparam logic [15:0] MIN_CUTOFF_RST   = 16'd256;
  localparam logic [15:0] SPEED_GAIN_RST   = 16'd0;
  localparam logic [15:0] DERIV_CUTOFF_RST = 16'd256;

  localparam logic [19:0] DEFAULT_STEP_US  = 20'd1000;
  localparam logic [19:0] USEC_PER_SEC     = 20'd1000000;
  localparam logic [18:0] TWO_PI_Q16       = 19'd411775;
  localparam logic [63:0] ALPHA_K          = 64'd16777216000000;
  localparam logic [59:0] ALPHA_N          = 60'd1099511627776000000;
  localparam logic [15:0] ALPHA_MAX        = 16'hFFFF;

  localparam int QUEUE_DEPTH = 2;

endpackage

[src/oef_front.sv]
`timescale 1ns / 1ps
module oef_front
  import oef_pkg::*;
#(
  parameter int CHANNELS = 64
) (
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // channel[5:0], sample[23:6], step_us[43:24]
  input  logic        in_tuser,   // req_type
  input  q_stat_t     qs,
  output logic        push,
  output item_t       push_item
);

  logic       xfer;
  logic       in_range;
  logic [5:0] ch;
  logic [19:0] us_raw;

  assign ch       = in_tdata[5:0];
  assign us_raw   = in_tdata[43:24];
  assign in_range = ({3'd0, ch} < 9'(CHANNELS));
  assign in_tready = rst_n && !qs.full;
  assign xfer     = in_tvalid && in_tready;

  // drop filter items aimed past the last channel
  assign push = xfer && (in_tuser || in_range);

  always_comb begin
    push_item.rst     = in_tuser;
    push_item.channel = ch;
    push_item.sample  = in_tdata[23:6];
    push_item.us      = (us_raw == 20'd0) ? DEFAULT_STEP_US : us_raw;
  end

endmodule

[src/oef_fifo.sv]
`timescale 1ns / 1ps
module oef_fifo
  import oef_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   head,
  output q_stat_t qs
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  item_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign head     = mem[rd_ptr_r];
  assign qs.full  = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign qs.empty = (cnt_r == '0);

endmodule

[src/oef_alpha.sv]
`timescale 1ns / 1ps
module oef_alpha
  import oef_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  alpha_req_t req,
  output alpha_rsp_t rsp
);

  alpha_st_t   st_r, st_nxt;
  logic [51:0] t_r;
  logic [62:0] acc_r;
  logic [79:0] dsh_r;
  logic [59:0] rem_r;
  logic [16:0] q_r;
  logic [4:0]  cnt_r;
  logic [15:0] alpha_r;

  logic [40:0] hi_p;
  logic [79:0] rem_ext;
  logic        fits;
  logic [16:0] q_fin;

  assign hi_p    = 41'(t_r[43:22]) * 41'(TWO_PI_Q16);
  assign rem_ext = {20'd0, rem_r};
  assign fits    = (rem_ext >= dsh_r);
  assign q_fin   = q_r + {16'd0, (rem_r != 60'd0)};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      A_IDLE: if (req.start) st_nxt = A_LO;
      A_LO:   st_nxt = (t_r[51:44] != 8'd0) ? A_DONE : A_HI;
      A_HI:   st_nxt = A_DEN;
      A_DEN:  st_nxt = A_DIV;
      A_DIV:  if (cnt_r == 5'd0) st_nxt = A_FIN;
      A_FIN:  st_nxt = A_DONE;
      A_DONE: st_nxt = A_IDLE;
      default: st_nxt = A_IDLE;
    endcase
  end

  always_comb begin
    rsp.done  = (st_r == A_DONE);
    rsp.alpha = alpha_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      A_IDLE: begin
        if (req.start) t_r <= 52'(req.cut) * 52'(req.us);
      end
      A_LO: begin
        acc_r   <= 63'(t_r[21:0]) * 63'(TWO_PI_Q16);
        alpha_r <= ALPHA_MAX;
      end
      A_HI: begin
        acc_r <= acc_r + {hi_p, 22'd0};
      end
      A_DEN: begin
        dsh_r <= {ALPHA_K + {1'b0, acc_r}, 16'd0};
        rem_r <= ALPHA_N;
        q_r   <= '0;
        cnt_r <= 5'd16;
      end
      A_DIV: begin
        if (fits) rem_r <= 60'(rem_ext - dsh_r);
        q_r   <= {q_r[15:0], fits};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 5'd1;
      end
      A_FIN: begin
        alpha_r <= 16'(17'h10000 - q_fin);
      end
      default: ;
    endcase
  end

endmodule

[src/oef_back.sv]
`timescale 1ns / 1ps
module oef_back
  import oef_pkg::*;
#(
  parameter int CHANNELS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  item_t       head,
  input  q_stat_t     qs,
  output logic        pop,
  output alpha_req_t  areq,
  input  alpha_rsp_t  arsp,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  back_st_t           st_r, st_nxt;
  logic [CHANNELS-1:0] marks_r;
  logic [IDX_W-1:0]   idx_r;
  logic [5:0]         ch_r;
  logic signed [17:0] x_r, xp_r;
  logic [19:0]        us_r;
  logic signed [31:0] pd_r, d_r, dhat_r;
  logic               neg_r;
  logic [37:0]        nq_r;
  logic [19:0]        rem_r;
  logic [5:0]         cnt_r;
  logic [15:0]        a_r;
  logic signed [49:0] prod_r;
  logic [47:0]        gprod_r;
  logic [17:0]        res_val_r;
  logic               out_tvalid_r;
  logic [23:0]        out_tdata_r;

  logic [17:0]        pv_mem [CHANNELS];
  logic [31:0]        pd_mem [CHANNELS];
  logic [17:0]        rd_pv_r;
  logic [31:0]        rd_pd_r;

  logic [7:0]         head_ch8;
  logic [IDX_W-1:0]   head_idx, rd_addr, waddr;
  logic               head_first;
  logic               mem_we, out_load;
  logic [17:0]        wv;
  logic [31:0]        wd;

  logic signed [18:0] diff;
  logic [17:0]        absdiff;
  logic [37:0]        num;
  logic [20:0]        rem_sh;
  logic               ge;
  logic [19:0]        rem_new;
  logic signed [31:0] d_sat;
  logic signed [32:0] dd;
  logic signed [18:0] dx;
  logic signed [49:0] pr;
  logic signed [33:0] sh;
  logic signed [34:0] sum_d;
  logic signed [31:0] dhat_sat;
  logic [31:0]        mag;
  logic [17:0]        xhat;

  assign head_ch8   = {2'b00, head.channel};
  assign head_idx   = head_ch8[IDX_W-1:0];
  assign head_first = !marks_r[head_idx];

  assign diff    = 19'(x_r) - 19'($signed(rd_pv_r));
  assign absdiff = diff[18] ? 18'(-diff) : diff[17:0];
  assign num     = 38'(absdiff) * 38'(USEC_PER_SEC);

  assign rem_sh  = {rem_r, nq_r[37]};
  assign ge      = (rem_sh >= {1'b0, us_r});
  assign rem_new = ge ? 20'(rem_sh - {1'b0, us_r}) : rem_sh[19:0];

  always_comb begin
    if (!neg_r) begin
      d_sat = (nq_r > 38'h007FFFFFFF) ? 32'sh7FFFFFFF : $signed(nq_r[31:0]);
    end else begin
      d_sat = (nq_r > 38'h0080000000) ? 32'sh80000000 : $signed(32'(-nq_r[31:0]));
    end
  end

  assign dd    = 33'(d_r) - 33'(pd_r);
  assign dx    = 19'(x_r) - 19'(xp_r);
  assign pr    = prod_r + 50'sd32768;
  assign sh    = pr[49:16];
  assign sum_d = 35'(pd_r) + 35'(sh);

  always_comb begin
    if (sum_d > 35'sd2147483647) begin
      dhat_sat = 32'sh7FFFFFFF;
    end else if (sum_d < -35'sd2147483648) begin
      dhat_sat = 32'sh80000000;
    end else begin
      dhat_sat = sum_d[31:0];
    end
  end

  assign mag  = dhat_r[31] ? 32'(-dhat_r) : dhat_r;
  assign xhat = 18'(xp_r + $signed(pr[33:16]));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE: begin
        if (!qs.empty && !head.rst) st_nxt = head_first ? B_OUT : B_READ;
      end
      B_READ:    st_nxt = B_DIV;
      B_DIV:     if (cnt_r == 6'd0) st_nxt = B_DSAT;
      B_DSAT:    st_nxt = B_ALPHA_D;
      B_ALPHA_D: if (arsp.done) st_nxt = B_SMD_MUL;
      B_SMD_MUL: st_nxt = B_SMD_ADD;
      B_SMD_ADD: st_nxt = B_CUT_MUL;
      B_CUT_MUL: st_nxt = B_CUT;
      B_CUT:     st_nxt = B_ALPHA_X;
      B_ALPHA_X: if (arsp.done) st_nxt = B_SMX_MUL;
      B_SMX_MUL: st_nxt = B_SMX_ADD;
      B_SMX_ADD: st_nxt = B_OUT;
      B_OUT:     if (!out_tvalid_r || out_tready) st_nxt = B_IDLE;
      default:   st_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    mem_we   = 1'b0;
    waddr    = idx_r;
    wv       = 18'(xhat);
    wd       = dhat_r;
    out_load = 1'b0;
    areq.start = 1'b0;
    areq.cut   = 32'(cfg.deriv_cutoff);
    areq.us    = us_r;
    rd_addr  = idx_r;
    case (st_r)
      B_IDLE: begin
        rd_addr = head_idx;
        pop     = !qs.empty;
        if (!qs.empty && !head.rst && head_first) begin
          mem_we = 1'b1;
          waddr  = head_idx;
          wv     = head.sample;
          wd     = '0;
        end
      end
      B_DSAT: areq.start = 1'b1;
      B_CUT: begin
        areq.start = 1'b1;
        areq.cut   = 32'(cfg.min_cutoff) + gprod_r[47:16];
      end
      B_SMX_ADD: mem_we = 1'b1;
      B_OUT:     out_load = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= B_IDLE;
      marks_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (pop) begin
        if (head.rst) begin
          marks_r <= '0;
        end else begin
          marks_r[head_idx] <= 1'b1;
        end
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_pv_r <= pv_mem[rd_addr];
    rd_pd_r <= pd_mem[rd_addr];
    if (mem_we) begin
      pv_mem[waddr] <= wv;
      pd_mem[waddr] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_tdata_r <= {res_val_r, ch_r};
    case (st_r)
      B_IDLE: begin
        idx_r     <= head_idx;
        ch_r      <= head.channel;
        x_r       <= head.sample;
        us_r      <= head.us;
        res_val_r <= head.sample;
      end
      B_READ: begin
        xp_r  <= rd_pv_r;
        pd_r  <= rd_pd_r;
        neg_r <= diff[18];
        nq_r  <= num;
        rem_r <= '0;
        cnt_r <= 6'd37;
      end
      B_DIV: begin
        rem_r <= rem_new;
        nq_r  <= {nq_r[36:0], ge};
        cnt_r <= cnt_r - 6'd1;
      end
      B_DSAT:    d_r <= d_sat;
      B_ALPHA_D: if (arsp.done) a_r <= arsp.alpha;
      B_SMD_MUL: prod_r <= 50'(dd) * 50'($signed({1'b0, a_r}));
      B_SMD_ADD: dhat_r <= dhat_sat;
      B_CUT_MUL: gprod_r <= 48'(cfg.speed_gain) * 48'(mag);
      B_ALPHA_X: if (arsp.done) a_r <= arsp.alpha;
      B_SMX_MUL: prod_r <= 50'(dx) * 50'($signed({1'b0, a_r}));
      B_SMX_ADD: res_val_r <= xhat;
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[src/one_euro_filter_bank.sv]
// A seeded channel's sample passes from queue head to result valid through the 38-step derivative divide
//   and two alpha divides (each divide skipped if the cutoff-time product saturates).
// First sample of a channel: passed through as its result. Reset item: no result.
// Throughput: one item at a time in the back end; a 2-entry queue takes input meanwhile.
// Reset (rst_n low, synchronous): clears started marks, queue, and result valid;
//   registers return to min_cutoff 256, speed_gain 0, deriv_cutoff 256.
`timescale 1ns / 1ps
`include "one_euro_filter_bank_defines.svh"
module one_euro_filter_bank
  import oef_pkg::*;
#(
  parameter int CHANNELS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // channel[5:0], sample[23:6], step_us[43:24]
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_channel[5:0], filtered[23:6]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t       cfg_r;
  logic       push, pop;
  item_t      push_item, head;
  q_stat_t    qs;
  alpha_req_t areq;
  alpha_rsp_t arsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_cutoff   <= MIN_CUTOFF_RST;
      cfg_r.speed_gain   <= SPEED_GAIN_RST;
      cfg_r.deriv_cutoff <= DERIV_CUTOFF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_CUTOFF:   cfg_r.min_cutoff   <= cfg_data;
        REG_SPEED_GAIN:   cfg_r.speed_gain   <= cfg_data;
        REG_DERIV_CUTOFF: cfg_r.deriv_cutoff <= cfg_data;
        default: ;
      endcase
    end
  end

  oef_front #(.CHANNELS(CHANNELS)) u_front (
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .qs        (qs),
    .push      (push),
    .push_item (push_item)
  );

  oef_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qs        (qs)
  );

  oef_alpha u_alpha (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .rsp   (arsp)
  );

  oef_back #(.CHANNELS(CHANNELS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .qs         (qs),
    .pop        (pop),
    .areq       (areq),
    .arsp       (arsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `OEF_ASSERT_IMP(a_no_push_full, push, !qs.full, "push into full queue")
  `OEF_ASSERT_IMP(a_no_pop_empty, pop, !qs.empty, "pop from empty queue")
  `OEF_ASSERT_NXT(a_push_fills, push && !pop, !qs.empty, "queue lost a pushed item")
  `OEF_ASSERT_IMP(a_out_ch, out_tvalid, ({3'd0, out_tdata[5:0]} < 9'(CHANNELS)), "bad channel")

endmodule
